>>> rtl/ogrp_pkg.sv
// Shared types, constants and helper functions for the occupancy grid ray proximity block.
`timescale 1ns / 1ps

package ogrp_pkg;

   localparam int MAX_COLUMNS_DEF = 256;
   localparam int MAX_ROWS_DEF = 256;
   localparam int MAX_STEPS_DEF = 1024;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [19:0] CELL_SIZE_RST = 20'd3277;
   localparam logic [8:0] MAP_COLUMNS_RST = 9'd256;
   localparam logic [8:0] MAP_ROWS_RST = 9'd256;
   localparam logic [7:0] OCCUPIED_LEVEL_RST = 8'd166;

   localparam logic signed [33:0] Q28_PI = 34'sd843314857;
   localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
   localparam logic signed [33:0] Q28_TWO_PI = 34'sd1686629713;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam int CORDIC_ITERS = 28;

   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 23;

   typedef struct packed {
      logic operation;
      logic [7:0] pixel_column;
      logic [7:0] pixel_image_row;
      logic [7:0] pixel_level;
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic signed [15:0] ray_angle;
      logic [22:0] ray_length;
   } req_type;

   typedef struct packed {
      logic [15:0] proximity;
      logic hit;
   } rsp_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CELL_SIZE,
      REG_MAP_ORIGIN_X,
      REG_MAP_ORIGIN_Y,
      REG_MAP_COLUMNS,
      REG_MAP_ROWS,
      REG_INVERT_PIXELS,
      REG_OCCUPIED_LEVEL,
      REG_MAP_VALID
   } csr_index_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_START,
      CMD_REDUCE,
      CMD_FOLD,
      CMD_ROTATE,
      CMD_TRIG,
      CMD_DIV_N,
      CMD_SET_N,
      CMD_DIV_QR,
      CMD_SET_QR,
      CMD_DIV_R,
      CMD_SET_R,
      CMD_ADVANCE,
      CMD_MUL,
      CMD_OFFSET,
      CMD_RECIP,
      CMD_MULQ,
      CMD_ADDR,
      CMD_DIV_P,
      CMD_EMIT_HIT,
      CMD_EMIT_ZERO
   } cmd_type;

   typedef struct packed {
      logic z_in_range;
      logic rot_last;
      logic div_done;
      logic invalid;
      logic blocked;
      logic last_step;
      logic out_free;
   } stat_type;

   function automatic logic signed [33:0] atan_q28(input logic [4:0] idx);
      logic signed [33:0] val;
      case (idx)
         5'd0: val = 34'sd210828714;
         5'd1: val = 34'sd124459457;
         5'd2: val = 34'sd65760959;
         5'd3: val = 34'sd33381290;
         5'd4: val = 34'sd16755422;
         5'd5: val = 34'sd8385879;
         5'd6: val = 34'sd4193963;
         5'd7: val = 34'sd2097109;
         5'd8: val = 34'sd1048571;
         5'd9: val = 34'sd524287;
         5'd10: val = 34'sd262144;
         5'd11: val = 34'sd131072;
         5'd12: val = 34'sd65536;
         5'd13: val = 34'sd32768;
         5'd14: val = 34'sd16384;
         5'd15: val = 34'sd8192;
         5'd16: val = 34'sd4096;
         5'd17: val = 34'sd2048;
         5'd18: val = 34'sd1024;
         5'd19: val = 34'sd512;
         5'd20: val = 34'sd256;
         5'd21: val = 34'sd128;
         5'd22: val = 34'sd64;
         5'd23: val = 34'sd32;
         5'd24: val = 34'sd16;
         5'd25: val = 34'sd8;
         5'd26: val = 34'sd4;
         5'd27: val = 34'sd2;
         default: val = 34'sd0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/occupancy_grid_ray_proximity.sv
// Top level of the occupancy grid ray proximity block.
`timescale 1ns / 1ps

// A pixel load is taken without stalling the input and gives no result. A query walks the ray in
// n = max(2, ceil(2*ray_length/cell_size)) steps, capped at MAX_STEPS, and returns one
// result. A query passes through a check, an angle reduction that adds or subtracts 2*pi
// once when the angle lies outside [-pi, pi], one fold, 28 CORDIC iterations, a latch of
// cosine and sine, three divisions on the shared restoring divider for the step count,
// the per-step increment and the cell reciprocal, and then for each step the multipliers
// and the grid memory read. A miss then emits its result, and a hit first needs a
// proximity division. A result waits until the previous result has been taken.
// Queries with a cleared map_valid, a zero radius or a zero cell size go from the check
// straight to a zero result. The input is stalled from a query transfer until its
// result is registered. The grid memory needs no clearing after reset; every cell must be
// loaded before a ray reaches it. Configuration writes are taken every cycle and belong
// only to idle periods.
module occupancy_grid_ray_proximity #(
   parameter int MAX_COLUMNS = ogrp_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS = ogrp_pkg::MAX_ROWS_DEF,
   parameter int MAX_STEPS = ogrp_pkg::MAX_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ogrp_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ogrp_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ogrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ogrp_pkg::CSR_DATA_W-1:0]  csr_data
);

   ogrp_pkg::cmd_type  cmd;
   ogrp_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ogrp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_query(req_data.operation),
      .req_stall(req_stall),
      .stat(stat),
      .cmd(cmd)
   );

   ogrp_dpath #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS(MAX_ROWS),
      .MAX_STEPS(MAX_STEPS)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

endmodule

>>> rtl/ogrp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ogrp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ogrp_div.sv
// Iterative restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module ogrp_div #(
   parameter int NUM_W = ogrp_pkg::DIV_NUM_W,
   parameter int DEN_W = ogrp_pkg::DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo,
   output logic [DEN_W-1:0] rem
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   shifted;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign fits = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff <= CW'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? DEN_W'(shifted - {1'b0, den_ff}) : DEN_W'(shifted);
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;
   assign rem = rem_ff;

endmodule

>>> rtl/ogrp_dpath.sv
// Datapath: configuration registers, grid memory, CORDIC, step arithmetic and result register.
`timescale 1ns / 1ps

module ogrp_dpath #(
   parameter int MAX_COLUMNS = ogrp_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS = ogrp_pkg::MAX_ROWS_DEF,
   parameter int MAX_STEPS = ogrp_pkg::MAX_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ogrp_pkg::cmd_type                  cmd,
   output ogrp_pkg::stat_type                 stat,
   input  ogrp_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ogrp_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr,
   input  logic [ogrp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ogrp_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(MAX_STEPS + 1);
   localparam int DNW = ogrp_pkg::DIV_NUM_W;
   localparam int DDW = ogrp_pkg::DIV_DEN_W;
   localparam logic [AW-1:0] COL_STRIDE = AW'(MAX_COLUMNS);

   logic [19:0]        cs_ff;
   logic signed [31:0] ox_ff;
   logic signed [31:0] oy_ff;
   logic [8:0]         cols_ff;
   logic [8:0]         rows_ff;
   logic               inv_ff;
   logic [7:0]         lvl_ff;
   logic               mvalid_ff;
   logic               rsp_valid_ff;
   ogrp_pkg::rsp_type  rsp_ff;

   logic [8:0]  cols_u;
   logic [8:0]  rows_u;
   logic [28:0] limx_ff;
   logic [28:0] limy_ff;

   logic signed [31:0] px_ff;
   logic signed [31:0] py_ff;
   logic [22:0]        rad_ff;
   logic signed [33:0] z_ff;
   logic               neg_ff;
   logic signed [33:0] x_ff;
   logic signed [33:0] y_ff;
   logic [4:0]         i_ff;
   logic signed [33:0] cos_ff;
   logic signed [33:0] sin_ff;
   logic [NW-1:0]      n_ff;
   logic [22:0]        q0_ff;
   logic [NW-1:0]      r0_ff;
   logic [28:0]        rcp_ff;
   logic [22:0]        d_ff;
   logic [NW-1:0]      racc_ff;
   logic [NW-1:0]      k_ff;
   logic signed [57:0] prx_ff;
   logic signed [57:0] pry_ff;
   logic signed [34:0] vx_ff;
   logic signed [34:0] vy_ff;
   logic               offx_ff;
   logic               offy_ff;
   logic [7:0]         qex_ff;
   logic [7:0]         qey_ff;
   logic [27:0]        mx_ff;
   logic [27:0]        my_ff;

   logic               div_start;
   logic [DNW-1:0]     div_num;
   logic [DDW-1:0]     div_den;
   logic               div_done;
   logic [DNW-1:0]     div_quo;
   logic [DDW-1:0]     div_rem;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               wr_occ;
   logic [7:0]         wr_row;
   logic [7:0]         pix;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               rd_data;

   logic signed [33:0] sx;
   logic signed [33:0] sy;
   logic signed [33:0] atan_i;
   logic [NW:0]        rsum;
   logic               rcarry;
   logic [39:0]        n_raw;
   logic signed [57:0] shx;
   logic signed [57:0] shy;
   logic [56:0]        prodx;
   logic [56:0]        prody;
   logic [28:0]        remx;
   logic [28:0]        remy;
   logic [7:0]         cx;
   logic [7:0]         cy;
   logic               out_free;

   assign cols_u = (32'(cols_ff) > MAX_COLUMNS) ? 9'(MAX_COLUMNS) : cols_ff;
   assign rows_u = (32'(rows_ff) > MAX_ROWS) ? 9'(MAX_ROWS) : rows_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Configuration registers, result valid and the map extent in world units.
   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= ogrp_pkg::CELL_SIZE_RST;
         ox_ff <= '0;
         oy_ff <= '0;
         cols_ff <= ogrp_pkg::MAP_COLUMNS_RST;
         rows_ff <= ogrp_pkg::MAP_ROWS_RST;
         inv_ff <= 1'b0;
         lvl_ff <= ogrp_pkg::OCCUPIED_LEVEL_RST;
         mvalid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (ogrp_pkg::csr_index_type'(csr_index))
               ogrp_pkg::REG_CELL_SIZE: cs_ff <= csr_data[19:0];
               ogrp_pkg::REG_MAP_ORIGIN_X: ox_ff <= $signed(csr_data);
               ogrp_pkg::REG_MAP_ORIGIN_Y: oy_ff <= $signed(csr_data);
               ogrp_pkg::REG_MAP_COLUMNS: cols_ff <= csr_data[8:0];
               ogrp_pkg::REG_MAP_ROWS: rows_ff <= csr_data[8:0];
               ogrp_pkg::REG_INVERT_PIXELS: inv_ff <= csr_data[0];
               ogrp_pkg::REG_OCCUPIED_LEVEL: lvl_ff <= csr_data[7:0];
               ogrp_pkg::REG_MAP_VALID: mvalid_ff <= csr_data[0];
               default: mvalid_ff <= mvalid_ff;
            endcase
         end
         if (cmd == ogrp_pkg::CMD_EMIT_HIT || cmd == ogrp_pkg::CMD_EMIT_ZERO) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      limx_ff <= 29'(cols_u) * 29'(cs_ff);
      limy_ff <= 29'(rows_u) * 29'(cs_ff);
   end

   // Pixel load into the grid, rows flipped so that grid row 0 is the bottom.
   assign pix = inv_ff ? req_data.pixel_level : 8'd255 - req_data.pixel_level;
   assign wr_occ = pix >= lvl_ff;
   assign wr_row = 8'(rows_u - 9'd1 - {1'b0, req_data.pixel_image_row});
   assign wr_addr = AW'(wr_row) * COL_STRIDE + AW'(req_data.pixel_column);
   assign wr_en = (cmd == ogrp_pkg::CMD_LOAD)
                  && ({1'b0, req_data.pixel_column} < cols_u)
                  && ({1'b0, req_data.pixel_image_row} < rows_u);

   assign remx = vx_ff[28:0] - 29'(mx_ff);
   assign remy = vy_ff[28:0] - 29'(my_ff);
   assign cx = qex_ff + 8'(remx >= 29'(cs_ff));
   assign cy = qey_ff + 8'(remy >= 29'(cs_ff));
   assign rd_addr = AW'(cy) * COL_STRIDE + AW'(cx);
   assign rd_en = (cmd == ogrp_pkg::CMD_ADDR) && !offx_ff && !offy_ff;

   ogrp_ram #(
      .WIDTH(1),
      .DEPTH(DEPTH)
   ) u_grid (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_occ),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      case (cmd)
         ogrp_pkg::CMD_DIV_N: begin
            div_start = 1'b1;
            div_num = DNW'({rad_ff, 1'b0}) + DNW'(cs_ff) - DNW'(1);
            div_den = DDW'(cs_ff);
         end
         ogrp_pkg::CMD_DIV_QR: begin
            div_start = 1'b1;
            div_num = DNW'(rad_ff);
            div_den = DDW'(n_ff);
         end
         ogrp_pkg::CMD_DIV_R: begin
            div_start = 1'b1;
            div_num = DNW'(1) << 28;
            div_den = DDW'(cs_ff);
         end
         ogrp_pkg::CMD_DIV_P: begin
            div_start = 1'b1;
            div_num = DNW'(rad_ff - d_ff) << 16;
            div_den = rad_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   ogrp_div #(
      .NUM_W(DNW),
      .DEN_W(DDW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .done(div_done),
      .quo(div_quo),
      .rem(div_rem)
   );

   assign sx = x_ff >>> i_ff;
   assign sy = y_ff >>> i_ff;
   assign atan_i = ogrp_pkg::atan_q28(i_ff);
   assign rsum = (NW + 1)'(racc_ff) + (NW + 1)'(r0_ff);
   assign rcarry = rsum >= (NW + 1)'(n_ff);
   assign n_raw = div_quo;
   assign shx = prx_ff >>> 30;
   assign shy = pry_ff >>> 30;
   assign prodx = 57'(vx_ff[27:0]) * 57'(rcp_ff);
   assign prody = 57'(vy_ff[27:0]) * 57'(rcp_ff);

   always_ff @(posedge clock) begin
      case (cmd)
         ogrp_pkg::CMD_START: begin
            px_ff <= req_data.pose_x;
            py_ff <= req_data.pose_y;
            rad_ff <= req_data.ray_length;
            z_ff <= {{2{req_data.ray_angle[15]}}, req_data.ray_angle, 16'd0};
         end
         ogrp_pkg::CMD_REDUCE: begin
            if (z_ff > ogrp_pkg::Q28_PI) begin
               z_ff <= z_ff - ogrp_pkg::Q28_TWO_PI;
            end else begin
               z_ff <= z_ff + ogrp_pkg::Q28_TWO_PI;
            end
         end
         ogrp_pkg::CMD_FOLD: begin
            x_ff <= ogrp_pkg::CORDIC_GAIN;
            y_ff <= '0;
            i_ff <= '0;
            if (z_ff > ogrp_pkg::Q28_HALF_PI) begin
               z_ff <= z_ff - ogrp_pkg::Q28_PI;
               neg_ff <= 1'b1;
            end else if (z_ff < -ogrp_pkg::Q28_HALF_PI) begin
               z_ff <= z_ff + ogrp_pkg::Q28_PI;
               neg_ff <= 1'b1;
            end else begin
               neg_ff <= 1'b0;
            end
         end
         ogrp_pkg::CMD_ROTATE: begin
            i_ff <= i_ff + 5'd1;
            if (!z_ff[33]) begin
               x_ff <= x_ff - sy;
               y_ff <= y_ff + sx;
               z_ff <= z_ff - atan_i;
            end else begin
               x_ff <= x_ff + sy;
               y_ff <= y_ff - sx;
               z_ff <= z_ff + atan_i;
            end
         end
         ogrp_pkg::CMD_TRIG: begin
            cos_ff <= neg_ff ? -x_ff : x_ff;
            sin_ff <= neg_ff ? -y_ff : y_ff;
         end
         ogrp_pkg::CMD_SET_N: begin
            if (n_raw < 40'd2) begin
               n_ff <= NW'(2);
            end else if (n_raw > 40'(MAX_STEPS)) begin
               n_ff <= NW'(MAX_STEPS);
            end else begin
               n_ff <= NW'(n_raw);
            end
         end
         ogrp_pkg::CMD_SET_QR: begin
            q0_ff <= 23'(div_quo);
            r0_ff <= NW'(div_rem);
         end
         ogrp_pkg::CMD_SET_R: begin
            rcp_ff <= 29'(div_quo);
            d_ff <= '0;
            racc_ff <= '0;
            k_ff <= '0;
         end
         ogrp_pkg::CMD_ADVANCE: begin
            k_ff <= k_ff + NW'(1);
            racc_ff <= rcarry ? NW'(rsum - (NW + 1)'(n_ff)) : NW'(rsum);
            d_ff <= d_ff + q0_ff + 23'(rcarry);
         end
         ogrp_pkg::CMD_MUL: begin
            prx_ff <= 58'($signed({1'b0, d_ff})) * 58'(cos_ff);
            pry_ff <= 58'($signed({1'b0, d_ff})) * 58'(sin_ff);
         end
         ogrp_pkg::CMD_OFFSET: begin
            vx_ff <= 35'(px_ff) + 35'(shx) - 35'(ox_ff);
            vy_ff <= 35'(py_ff) + 35'(shy) - 35'(oy_ff);
         end
         ogrp_pkg::CMD_RECIP: begin
            offx_ff <= vx_ff[34] || (vx_ff[33:0] >= 34'(limx_ff));
            offy_ff <= vy_ff[34] || (vy_ff[33:0] >= 34'(limy_ff));
            qex_ff <= prodx[35:28];
            qey_ff <= prody[35:28];
         end
         ogrp_pkg::CMD_MULQ: begin
            mx_ff <= 28'(qex_ff) * 28'(cs_ff);
            my_ff <= 28'(qey_ff) * 28'(cs_ff);
         end
         ogrp_pkg::CMD_EMIT_HIT: begin
            rsp_ff.proximity <= (div_quo > 40'd65535) ? 16'hFFFF : div_quo[15:0];
            rsp_ff.hit <= 1'b1;
         end
         ogrp_pkg::CMD_EMIT_ZERO: begin
            rsp_ff.proximity <= '0;
            rsp_ff.hit <= 1'b0;
         end
         default: i_ff <= i_ff;
      endcase
   end

   assign stat.z_in_range = (z_ff <= ogrp_pkg::Q28_PI) && (z_ff >= -ogrp_pkg::Q28_PI);
   assign stat.rot_last = i_ff == 5'(ogrp_pkg::CORDIC_ITERS - 1);
   assign stat.div_done = div_done;
   assign stat.invalid = !mvalid_ff || (rad_ff == '0) || (cs_ff == '0);
   assign stat.blocked = offx_ff || offy_ff || rd_data;
   assign stat.last_step = k_ff == n_ff;
   assign stat.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

>>> rtl/ogrp_ctrl.sv
// Controller state machine that sequences pixel loads and ray queries.
`timescale 1ns / 1ps

module ogrp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_query,
   output logic               req_stall,
   input  ogrp_pkg::stat_type stat,
   output ogrp_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_REDUCE,
      S_FOLD,
      S_ROT,
      S_TRIG,
      S_DIVN,
      S_WAITN,
      S_DIVQ,
      S_WAITQ,
      S_DIVR,
      S_WAITR,
      S_ADV,
      S_MUL,
      S_OFS,
      S_RCP,
      S_MQ,
      S_ADR,
      S_TST,
      S_DIVP,
      S_WAITP,
      S_HIT,
      S_ZERO
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = ogrp_pkg::CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_query) begin
                  cmd = ogrp_pkg::CMD_START;
                  state_in = S_CHECK;
               end else begin
                  cmd = ogrp_pkg::CMD_LOAD;
               end
            end
         end
         S_CHECK: state_in = stat.invalid ? S_ZERO : S_REDUCE;
         S_REDUCE: begin
            if (stat.z_in_range) begin
               state_in = S_FOLD;
            end else begin
               cmd = ogrp_pkg::CMD_REDUCE;
            end
         end
         S_FOLD: begin
            cmd = ogrp_pkg::CMD_FOLD;
            state_in = S_ROT;
         end
         S_ROT: begin
            cmd = ogrp_pkg::CMD_ROTATE;
            if (stat.rot_last) begin
               state_in = S_TRIG;
            end
         end
         S_TRIG: begin
            cmd = ogrp_pkg::CMD_TRIG;
            state_in = S_DIVN;
         end
         S_DIVN: begin
            cmd = ogrp_pkg::CMD_DIV_N;
            state_in = S_WAITN;
         end
         S_WAITN: begin
            if (stat.div_done) begin
               cmd = ogrp_pkg::CMD_SET_N;
               state_in = S_DIVQ;
            end
         end
         S_DIVQ: begin
            cmd = ogrp_pkg::CMD_DIV_QR;
            state_in = S_WAITQ;
         end
         S_WAITQ: begin
            if (stat.div_done) begin
               cmd = ogrp_pkg::CMD_SET_QR;
               state_in = S_DIVR;
            end
         end
         S_DIVR: begin
            cmd = ogrp_pkg::CMD_DIV_R;
            state_in = S_WAITR;
         end
         S_WAITR: begin
            if (stat.div_done) begin
               cmd = ogrp_pkg::CMD_SET_R;
               state_in = S_ADV;
            end
         end
         S_ADV: begin
            cmd = ogrp_pkg::CMD_ADVANCE;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd = ogrp_pkg::CMD_MUL;
            state_in = S_OFS;
         end
         S_OFS: begin
            cmd = ogrp_pkg::CMD_OFFSET;
            state_in = S_RCP;
         end
         S_RCP: begin
            cmd = ogrp_pkg::CMD_RECIP;
            state_in = S_MQ;
         end
         S_MQ: begin
            cmd = ogrp_pkg::CMD_MULQ;
            state_in = S_ADR;
         end
         S_ADR: begin
            cmd = ogrp_pkg::CMD_ADDR;
            state_in = S_TST;
         end
         S_TST: begin
            if (stat.blocked) begin
               state_in = S_DIVP;
            end else if (stat.last_step) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_ADV;
            end
         end
         S_DIVP: begin
            cmd = ogrp_pkg::CMD_DIV_P;
            state_in = S_WAITP;
         end
         S_WAITP: begin
            if (stat.div_done) begin
               state_in = S_HIT;
            end
         end
         S_HIT: begin
            if (stat.out_free) begin
               cmd = ogrp_pkg::CMD_EMIT_HIT;
               state_in = S_IDLE;
            end
         end
         S_ZERO: begin
            if (stat.out_free) begin
               cmd = ogrp_pkg::CMD_EMIT_ZERO;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

>>> tb/ogrp_ray_checker.sv
// Checker that predicts and compares every result of the occupancy grid ray proximity block.
`timescale 1ns / 1ps

module ogrp_ray_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  ogrp_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  ogrp_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ogrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ogrp_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               fail_count,
   output int                               pending_results
);

   localparam int GRID_COLS = 256;
   localparam int GRID_ROWS = 256;
   localparam int STEP_CAP = 1024;

   longint arctan_q28 [28] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
      2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

   logic [19:0] cell_size;
   longint map_ox, map_oy;
   logic [8:0] cols_reg, rows_reg;
   logic invert, map_ok;
   logic [7:0] occ_level;
   bit occupied [GRID_COLS*GRID_ROWS];
   ogrp_pkg::rsp_type proximity_queue [$];

   initial begin
      fail_count = 0;
      pending_results = 0;
   end

   function automatic longint cols_used();
      return (cols_reg < GRID_COLS) ? longint'(cols_reg) : longint'(GRID_COLS);
   endfunction

   function automatic longint rows_used();
      return (rows_reg < GRID_ROWS) ? longint'(rows_reg) : longint'(GRID_ROWS);
   endfunction

   function automatic longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic ogrp_pkg::rsp_type predict_proximity(ogrp_pkg::req_type r);
      longint z, x, y, nx, cs, sn, rad, n, d, wx, wy, cx, cy, prox;
      bit neg, blocked;
      ogrp_pkg::rsp_type o;
      o = '0;
      rad = longint'(r.ray_length);
      if (!map_ok || rad == 0 || cell_size == 0) return o;
      z = longint'($signed(r.ray_angle)) * 65536;
      neg = 0;
      while (z > 843314857) z = z - 1686629713;
      while (z < -843314857) z = z + 1686629713;
      if (z > 421657428) begin
         z = z - 843314857;
         neg = 1;
      end else if (z < -421657428) begin
         z = z + 843314857;
         neg = 1;
      end
      x = 652032874;
      y = 0;
      for (int i = 0; i < 28; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - arctan_q28[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + arctan_q28[i];
         end
         x = nx;
      end
      cs = neg ? -x : x;
      sn = neg ? -y : y;
      n = (2 * rad + longint'(cell_size) - 1) / longint'(cell_size);
      if (n < 2) n = 2;
      if (n > STEP_CAP) n = STEP_CAP;
      for (longint k = 1; k <= n; k++) begin
         d = rad * k / n;
         wx = longint'($signed(r.pose_x)) + ((d * cs) >>> 30);
         wy = longint'($signed(r.pose_y)) + ((d * sn) >>> 30);
         cx = floor_quot(wx - map_ox, longint'(cell_size));
         cy = floor_quot(wy - map_oy, longint'(cell_size));
         if (cx < 0 || cy < 0 || cx >= cols_used() || cy >= rows_used()) blocked = 1;
         else blocked = occupied[cy * GRID_COLS + cx];
         if (blocked) begin
            prox = (rad - d) * 65536 / rad;
            if (prox > 65535) prox = 65535;
            if (prox < 0) prox = 0;
            o.proximity = prox[15:0];
            o.hit = 1'b1;
            return o;
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      ogrp_pkg::rsp_type want;
      longint p;
      if (reset) begin
         cell_size <= ogrp_pkg::CELL_SIZE_RST;
         map_ox <= 0;
         map_oy <= 0;
         cols_reg <= ogrp_pkg::MAP_COLUMNS_RST;
         rows_reg <= ogrp_pkg::MAP_ROWS_RST;
         invert <= 1'b0;
         occ_level <= ogrp_pkg::OCCUPIED_LEVEL_RST;
         map_ok <= 1'b0;
         proximity_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (proximity_queue.size() == 0) begin
               report_mismatch("outstanding query count", 0, 1);
            end else begin
               want = proximity_queue.pop_front();
               if (rsp_data.proximity !== want.proximity)
                  report_mismatch("proximity", longint'(rsp_data.proximity),
                                  longint'(want.proximity));
               if (rsp_data.hit !== want.hit)
                  report_mismatch("hit", longint'(rsp_data.hit), longint'(want.hit));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.operation) begin
               proximity_queue = {proximity_queue, predict_proximity(req_data)};
            end else if (req_data.pixel_column < cols_used()
                         && req_data.pixel_image_row < rows_used()) begin
               p = invert ? longint'(req_data.pixel_level)
                          : 255 - longint'(req_data.pixel_level);
               occupied[(rows_used() - 1 - req_data.pixel_image_row) * GRID_COLS
                        + req_data.pixel_column] = (p >= occ_level);
            end
         end
         if (csr_valid && csr_ready) begin
            case (ogrp_pkg::csr_index_type'(csr_index))
               ogrp_pkg::REG_CELL_SIZE: cell_size <= csr_data[19:0];
               ogrp_pkg::REG_MAP_ORIGIN_X: map_ox <= longint'($signed(csr_data));
               ogrp_pkg::REG_MAP_ORIGIN_Y: map_oy <= longint'($signed(csr_data));
               ogrp_pkg::REG_MAP_COLUMNS: cols_reg <= csr_data[8:0];
               ogrp_pkg::REG_MAP_ROWS: rows_reg <= csr_data[8:0];
               ogrp_pkg::REG_INVERT_PIXELS: invert <= csr_data[0];
               ogrp_pkg::REG_OCCUPIED_LEVEL: occ_level <= csr_data[7:0];
               ogrp_pkg::REG_MAP_VALID: map_ok <= csr_data[0];
               default: ;
            endcase
         end
      end
      pending_results <= proximity_queue.size();
   end

endmodule

>>> tb/tb_occupancy_grid_ray_proximity.sv
// Top of the occupancy grid ray proximity testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_occupancy_grid_ray_proximity;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   ogrp_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   ogrp_pkg::rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [ogrp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ogrp_pkg::CSR_DATA_W-1:0] csr_data = '0;
   int fail_count, pending_results;
   bit quiet = 0;
   bit long_hold = 0;

   occupancy_grid_ray_proximity DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   ogrp_ray_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_results(pending_results)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("occupancy_grid_ray_proximity regression: fail");
      $finish;
   end

   initial begin
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (3000) @(negedge clock);
            long_hold = 0;
         end else if (burst > 0) begin
            rsp_stall <= 1;
            burst--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            burst = $urandom_range(1, 9) - 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic send_item(ogrp_pkg::req_type r);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(ogrp_pkg::csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      wait (pending_results == 0);
      repeat (400) @(negedge clock);
   endtask

   function automatic ogrp_pkg::req_type noise_item();
      ogrp_pkg::req_type r;
      r = {$urandom, $urandom, $urandom, $urandom};
      r.ray_length = 23'($urandom_range(0, 4194304));
      return r;
   endfunction

   function automatic ogrp_pkg::req_type pixel_load(int col, int irow);
      ogrp_pkg::req_type r;
      r = noise_item();
      r.operation = 1'b0;
      r.pixel_column = 8'(col);
      r.pixel_image_row = 8'(irow);
      r.pixel_level = 8'($urandom);
      return r;
   endfunction

   function automatic ogrp_pkg::req_type ray_query(int cols, int rows, longint cs, longint ox,
                                                   longint oy);
      ogrp_pkg::req_type r;
      longint px, py, rad;
      r = noise_item();
      r.operation = 1'b1;
      px = ox + longint'($urandom_range(0, cols * cs)) - ($urandom_range(0, 7) == 0 ? cs : 0);
      py = oy + longint'($urandom_range(0, rows * cs));
      rad = longint'($urandom_range(0, 24)) * cs / 2 + $urandom_range(0, cs);
      if ($urandom_range(0, 30) == 0) rad = 4194304;
      if (rad > 4194304) rad = 4194304;
      r.pose_x = px[31:0];
      r.pose_y = py[31:0];
      r.ray_length = rad[22:0];
      return r;
   endfunction

   task automatic map_phase(int ph, int cols, int rows, longint cs, int inv, int lvl);
      longint ox, oy;
      int queries;
      ox = $signed($urandom);
      oy = $signed($urandom);
      if (ph == 1) ox = -2147483648;
      if (ph == 2) oy = 2147483647 - rows * cs;
      drain();
      write_reg(ogrp_pkg::REG_MAP_VALID, 0);
      write_reg(ogrp_pkg::REG_CELL_SIZE, cs[31:0]);
      write_reg(ogrp_pkg::REG_MAP_ORIGIN_X, ox[31:0]);
      write_reg(ogrp_pkg::REG_MAP_ORIGIN_Y, oy[31:0]);
      write_reg(ogrp_pkg::REG_MAP_COLUMNS, cols);
      write_reg(ogrp_pkg::REG_MAP_ROWS, rows);
      write_reg(ogrp_pkg::REG_INVERT_PIXELS, inv);
      write_reg(ogrp_pkg::REG_OCCUPIED_LEVEL, lvl);
      for (int row = 0; row < rows; row++)
         for (int col = 0; col < cols; col++) send_item(pixel_load(col, row));
      send_item(pixel_load(cols + $urandom_range(0, 255 - cols), $urandom));
      drain();
      write_reg(ogrp_pkg::REG_MAP_VALID, 1);
      queries = 43 + $urandom_range(0, 10);
      for (int q = 0; q < queries; q++) begin
         if (ph == 3 && q == 5) long_hold = 1;
         if (ph == 5 && q == 20) begin
            @(negedge clock);
            req_valid <= 0;
            wait (pending_results == 0);
         end
         if ($urandom_range(0, 9) == 0)
            send_item(pixel_load($urandom_range(0, cols - 1), $urandom_range(0, rows - 1)));
         else if ($urandom_range(0, 9) == 0) send_item(noise_item());
         else send_item(ray_query(cols, rows, cs, ox, oy));
      end
   endtask

   initial begin
      ogrp_pkg::req_type r;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      r = noise_item();
      r.operation = 1'b1;
      send_item(r);
      r.ray_length = 4194304;
      r.ray_angle = 16'sh8000;
      send_item(r);
      drain();
      write_reg(ogrp_pkg::REG_MAP_VALID, 1);
      write_reg(ogrp_pkg::REG_CELL_SIZE, 0);
      r.ray_angle = 16'sh7FFF;
      send_item(r);
      drain();
      write_reg(ogrp_pkg::REG_CELL_SIZE, 32'h000FFFFF);
      write_reg(ogrp_pkg::REG_MAP_COLUMNS, 0);
      send_item(pixel_load(0, 0));
      r.ray_length = 1;
      send_item(r);
      drain();
      write_reg(ogrp_pkg::REG_MAP_COLUMNS, 511);
      write_reg(ogrp_pkg::REG_MAP_ROWS, 0);
      r.ray_length = 23'h7FFFFF;
      send_item(r);

      map_phase(0, 4, 3, 1, 0, 0);
      map_phase(1, 3, 4, 655360, 1, 255);
      for (int ph = 2; ph < 8; ph++) begin
         if (ph == 7) quiet = 1;
         map_phase(ph, $urandom_range(1, 8), $urandom_range(1, 8),
                   $urandom_range(1, 200000), ph & 1, $urandom_range(60, 200));
      end

      drain();
      if (fail_count == 0) $display("occupancy_grid_ray_proximity regression: pass");
      else $display("occupancy_grid_ray_proximity regression: fail");
      $finish;
   end

endmodule
